// ===== sv/mdss_pkg.sv =====
package mdss_pkg;

    localparam int DRIVE_FIELDS = 7;
    localparam int MAX_DRIVES   = 7;
    localparam int IN_BITS      = 32;
    localparam int OUT_BITS     = 32;

    typedef enum logic [2:0] {
        ST_INIT   = 3'd0,
        ST_READY  = 3'd1,
        ST_ACTIVE = 3'd2,
        ST_FAULT  = 3'd3,
        ST_ESTOP  = 3'd4
    } sup_state_t;

    typedef logic [2:0] drive_status_t;

    localparam drive_status_t DS_SWON_DISABLED = 3'd1;
    localparam drive_status_t DS_READY         = 3'd2;
    localparam drive_status_t DS_SWITCHED_ON   = 3'd3;
    localparam drive_status_t DS_OP_ENABLED    = 3'd4;
    localparam drive_status_t DS_FAULT         = 3'd5;

    typedef logic [2:0] drive_cmd_t;

    localparam drive_cmd_t CMD_NONE          = 3'd0;
    localparam drive_cmd_t CMD_FAULT_RESET   = 3'd1;
    localparam drive_cmd_t CMD_SWITCH_ON     = 3'd2;
    localparam drive_cmd_t CMD_ALLOW_OP      = 3'd3;
    localparam drive_cmd_t CMD_FORCE_DISABLE = 3'd4;

    typedef logic [1:0] ctrl_sel_t;

    localparam ctrl_sel_t CTRL_NONE    = 2'd0;
    localparam ctrl_sel_t CTRL_GRAVITY = 2'd1;
    localparam ctrl_sel_t CTRL_ESTOP   = 2'd2;

    typedef struct packed {
        sup_state_t state;
        logic       enable;
        logic       reset_request;
    } lane_ctrl_t;

    typedef struct packed {
        logic op_enabled_ok;
        logic disabled_ok;
    } lane_flags_t;

endpackage

// ===== sv/mdss_lane.sv =====
module mdss_lane
(
    input  mdss_pkg::lane_ctrl_t    ctrl,
    input  mdss_pkg::drive_status_t status,
    output mdss_pkg::drive_cmd_t    cmd,
    output mdss_pkg::lane_flags_t   flags
);
    import mdss_pkg::*;

    always_comb
    begin
        flags.op_enabled_ok = !ctrl.enable || (status == DS_OP_ENABLED);
        flags.disabled_ok   = !ctrl.enable || (status == DS_SWON_DISABLED);
    end

    always_comb
    begin
        cmd = CMD_NONE;
        if (ctrl.enable)
        begin
            case (ctrl.state)
                ST_INIT:
                begin
                    if (status == DS_OP_ENABLED)
                        cmd = CMD_NONE;
                    else if (status == DS_FAULT)
                        cmd = CMD_FAULT_RESET;
                    else if (status <= DS_READY)
                        cmd = CMD_SWITCH_ON;
                    else if (status == DS_SWITCHED_ON)
                        cmd = CMD_ALLOW_OP;
                    else
                        cmd = CMD_FORCE_DISABLE;
                end
                ST_FAULT:
                begin
                    if (status == DS_SWON_DISABLED)
                        cmd = CMD_NONE;
                    else if (status == DS_FAULT && ctrl.reset_request)
                        cmd = CMD_FAULT_RESET;
                    else
                        cmd = CMD_FORCE_DISABLE;
                end
                ST_ESTOP:
                    cmd = CMD_FORCE_DISABLE;
                default:
                    cmd = CMD_NONE;
            endcase
        end
    end

endmodule

// ===== sv/mdss_sup.sv =====
module mdss_sup
(
    input  logic                                            clk,
    input  logic                                            rst_n,
    input  logic                                            advance,
    input  logic                                            estop_request,
    input  logic                                            fault_active,
    input  logic                                            trajectory_active,
    input  logic                                            reset_request,
    input  logic [2:0]                                      drive_count,
    input  mdss_pkg::lane_flags_t [mdss_pkg::DRIVE_FIELDS-1:0] flags,
    output mdss_pkg::lane_ctrl_t  [mdss_pkg::DRIVE_FIELDS-1:0] lane_ctrl,
    output mdss_pkg::sup_state_t                            state_next,
    output logic                                            switch_request,
    output mdss_pkg::ctrl_sel_t                             controller_select
);
    import mdss_pkg::*;

    localparam logic [2:0] CountCap =
        (MAX_DRIVES < DRIVE_FIELDS) ? 3'(MAX_DRIVES) : 3'(DRIVE_FIELDS);

    sup_state_t state_reg;
    sup_state_t eff_state;
    logic [2:0] active_count;
    logic       all_on;
    logic       all_dis;

    assign active_count = (drive_count > CountCap) ? CountCap : drive_count;

    always_comb
    begin
        if (estop_request)
            eff_state = ST_ESTOP;
        else if (fault_active && state_reg != ST_ESTOP)
            eff_state = ST_FAULT;
        else
            eff_state = state_reg;
    end

    always_comb
    begin
        all_on  = 1'b1;
        all_dis = 1'b1;
        for (int i = 0; i < DRIVE_FIELDS; i++)
        begin
            lane_ctrl[i].state         = eff_state;
            lane_ctrl[i].enable        = 3'(i) < active_count;
            lane_ctrl[i].reset_request = reset_request;
            all_on  = all_on  & flags[i].op_enabled_ok;
            all_dis = all_dis & flags[i].disabled_ok;
        end
    end

    always_comb
    begin
        state_next = eff_state;
        case (eff_state)
            ST_INIT:
                if (all_on && !fault_active && !estop_request)
                    state_next = ST_READY;
            ST_READY:
                if (trajectory_active && !fault_active && !estop_request)
                    state_next = ST_ACTIVE;
            ST_ACTIVE:
                if (!trajectory_active || fault_active || estop_request)
                    state_next = ST_READY;
            ST_FAULT:
                if (reset_request && !fault_active && all_dis && !estop_request)
                    state_next = ST_INIT;
            ST_ESTOP:
                if (!estop_request && reset_request && !fault_active)
                    state_next = ST_INIT;
            default:
                state_next = eff_state;
        endcase
    end

    always_comb
    begin
        switch_request    = 1'b0;
        controller_select = CTRL_NONE;
        case (eff_state)
            ST_INIT:
            begin
                if (all_on && !fault_active && !estop_request)
                begin
                    switch_request    = 1'b1;
                    controller_select = CTRL_GRAVITY;
                end
            end
            ST_READY:
            begin
                if (!(trajectory_active && !fault_active && !estop_request))
                begin
                    switch_request    = 1'b1;
                    controller_select = CTRL_GRAVITY;
                end
            end
            ST_ACTIVE:
            begin
                if (!trajectory_active && !fault_active && !estop_request)
                begin
                    switch_request    = 1'b1;
                    controller_select = CTRL_GRAVITY;
                end
            end
            ST_FAULT, ST_ESTOP:
            begin
                switch_request    = 1'b1;
                controller_select = CTRL_ESTOP;
            end
            default:
            begin
                switch_request    = 1'b0;
                controller_select = CTRL_NONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_INIT;
        else if (advance)
            state_reg <= state_next;
    end

endmodule

// ===== sv/multi_drive_safety_supervisor_top.sv =====
// Channel   Direction  Handshake                     Payload
// s_axis    in         s_axis_tvalid/s_axis_tready   s_axis_tdata[31:0] (one tick of flags)
// m_axis    out        m_axis_tvalid/m_axis_tready   m_axis_tdata[31:0] (state and commands)
// cfg       in         cfg_valid/cfg_ready           cfg_data[2:0] (drive_count)
//
// One tick is accepted per cycle when the output is not stalled; its result appears in the
// output register in the next cycle. The lane and supervisor next-state logic is combinational.
// Reset puts the supervisor in init and drive_count at seven; cfg_ready is always high.
// A stalled output holds its request and blocks input only while the output register is full
// and not being taken.
module multi_drive_safety_supervisor_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [0] estop_request, [1] fault_active, [2] trajectory_active, [3] reset_request,
    // [6:4] status_drive_0 .. [24:22] status_drive_6, [31:25] zero
    input  logic [31:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [2:0] app_state, [5:3] cmd_drive_0 .. [23:21] cmd_drive_6,
    // [24] switch_request, [26:25] controller_select, [31:27] zero
    output logic [31:0] m_axis_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_data
);
    import mdss_pkg::*;

    logic                            in_accept;
    logic [2:0]                      drive_count_reg;
    lane_ctrl_t  [DRIVE_FIELDS-1:0]  lane_ctrl;
    lane_flags_t [DRIVE_FIELDS-1:0]  lane_flags;
    drive_cmd_t  [DRIVE_FIELDS-1:0]  lane_cmd;
    sup_state_t                      state_next;
    logic                            switch_request;
    ctrl_sel_t                       controller_select;
    logic [OUT_BITS-1:0]             out_data_next;
    logic [OUT_BITS-1:0]             out_data_reg;
    logic                            out_valid_reg;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            drive_count_reg <= 3'd7;
        else if (cfg_valid)
            drive_count_reg <= cfg_data;
    end

    for (genvar g = 0; g < DRIVE_FIELDS; g++)
    begin : g_lane
        mdss_lane u_lane
        (
            .ctrl   (lane_ctrl[g]),
            .status (s_axis_tdata[4+3*g +: 3]),
            .cmd    (lane_cmd[g]),
            .flags  (lane_flags[g])
        );
    end

    mdss_sup u_sup
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .advance           (in_accept),
        .estop_request     (s_axis_tdata[0]),
        .fault_active      (s_axis_tdata[1]),
        .trajectory_active (s_axis_tdata[2]),
        .reset_request     (s_axis_tdata[3]),
        .drive_count       (drive_count_reg),
        .flags             (lane_flags),
        .lane_ctrl         (lane_ctrl),
        .state_next        (state_next),
        .switch_request    (switch_request),
        .controller_select (controller_select)
    );

    always_comb
    begin
        out_data_next      = '0;
        out_data_next[2:0] = state_next;
        for (int i = 0; i < DRIVE_FIELDS; i++)
            out_data_next[3+3*i +: 3] = lane_cmd[i];
        out_data_next[24]    = switch_request;
        out_data_next[26:25] = controller_select;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s_axis_tready)
            out_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
            out_data_reg <= out_data_next;
    end

    a_estop_wins: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && s_axis_tdata[0] |=> u_sup.state_reg == ST_ESTOP)
        else $error("estop request did not force estop state");

    a_no_switch_no_sel: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[24] |-> m_axis_tdata[26:25] == CTRL_NONE)
        else $error("controller select without switch request");

    a_safe_state_sel: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[2:0] == ST_ESTOP || m_axis_tdata[2:0] == ST_FAULT)
        |-> m_axis_tdata[24] && m_axis_tdata[26:25] == CTRL_ESTOP)
        else $error("fault or estop result without estop controller");

endmodule

// ===== bench/supervisor_checker.sv =====
`timescale 1ns / 1ps

module supervisor_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_data,
    output int unsigned mismatches,
    output int unsigned replies_pending,
    output int unsigned replies_checked,
    output logic [4:0]  states_seen
);
    import mdss_pkg::*;

    localparam int REPORT_LINES = 40;

    typedef struct packed {
        sup_state_t                    app_state;
        drive_cmd_t [DRIVE_FIELDS-1:0] cmd;
        logic                          switch_req;
        ctrl_sel_t                     sel;
    } reply_t;

    reply_t      expected_replies [$];
    sup_state_t  sup_state;
    logic [2:0]  drives_in_use;
    int unsigned mismatch_total;
    int unsigned checked_total;
    logic [4:0]  seen_mask;

    function automatic reply_t supervise_tick(input logic [31:0] tick, input logic [2:0] count,
                                              inout sup_state_t st);
        reply_t        r;
        logic          estop;
        logic          fault;
        logic          traj;
        logic          rst;
        logic          settled;
        drive_status_t s;
        int            n;
        estop = tick[0];
        fault = tick[1];
        traj  = tick[2];
        rst   = tick[3];
        n = (int'(count) > MAX_DRIVES) ? MAX_DRIVES : int'(count);
        if (n > DRIVE_FIELDS)
            n = DRIVE_FIELDS;
        r = '0;
        settled = 1'b1;

        // estop outranks fault, fault outranks the normal flow
        if (estop)
            st = ST_ESTOP;
        else if (fault && st != ST_ESTOP)
            st = ST_FAULT;

        case (st)
            ST_INIT:
            begin
                for (int i = 0; i < n; i++)
                begin
                    s = tick[4 + 3 * i +: 3];
                    if (s != DS_OP_ENABLED)
                    begin
                        settled = 1'b0;
                        if (s == DS_FAULT)
                            r.cmd[i] = CMD_FAULT_RESET;
                        else if (s <= DS_READY)
                            r.cmd[i] = CMD_SWITCH_ON;
                        else if (s == DS_SWITCHED_ON)
                            r.cmd[i] = CMD_ALLOW_OP;
                        else
                            r.cmd[i] = CMD_FORCE_DISABLE;
                    end
                end
                if (settled && !fault && !estop)
                begin
                    st = ST_READY;
                    r.switch_req = 1'b1;
                    r.sel = CTRL_GRAVITY;
                end
            end
            ST_READY:
            begin
                if (traj && !fault && !estop)
                    st = ST_ACTIVE;
                else
                begin
                    r.switch_req = 1'b1;
                    r.sel = CTRL_GRAVITY;
                end
            end
            ST_ACTIVE:
            begin
                if (!traj || fault || estop)
                begin
                    st = ST_READY;
                    if (!fault && !estop)
                    begin
                        r.switch_req = 1'b1;
                        r.sel = CTRL_GRAVITY;
                    end
                end
            end
            ST_FAULT:
            begin
                for (int i = 0; i < n; i++)
                begin
                    s = tick[4 + 3 * i +: 3];
                    if (s != DS_SWON_DISABLED)
                    begin
                        settled = 1'b0;
                        r.cmd[i] = (s == DS_FAULT && rst) ? CMD_FAULT_RESET : CMD_FORCE_DISABLE;
                    end
                end
                r.switch_req = 1'b1;
                r.sel = CTRL_ESTOP;
                if (rst && !fault && settled && !estop)
                    st = ST_INIT;
            end
            ST_ESTOP:
            begin
                for (int i = 0; i < n; i++)
                    r.cmd[i] = CMD_FORCE_DISABLE;
                r.switch_req = 1'b1;
                r.sel = CTRL_ESTOP;
                if (!estop && rst && !fault)
                    st = ST_INIT;
            end
            default:
            begin
            end
        endcase
        r.app_state = st;
        return r;
    endfunction

    task automatic report_mismatch(input string field, input int unsigned got,
                                   input int unsigned want);
        if (mismatch_total < REPORT_LINES)
            $display("%0t mismatch on result %0d, %s: got %0d, expected %0d",
                     $time, checked_total, field, got, want);
        mismatch_total++;
    endtask

    task automatic check_reply(input logic [31:0] got);
        reply_t want;
        if (expected_replies.size() == 0)
        begin
            report_mismatch("result with no request outstanding", got, 0);
            return;
        end
        want = expected_replies.pop_front();
        checked_total++;
        seen_mask[want.app_state] = 1'b1;
        if (got[2:0] != want.app_state)
            report_mismatch("app_state", got[2:0], want.app_state);
        for (int i = 0; i < DRIVE_FIELDS; i++)
            if (got[3 + 3 * i +: 3] != want.cmd[i])
                report_mismatch($sformatf("cmd_drive_%0d", i), got[3 + 3 * i +: 3], want.cmd[i]);
        if (got[24] != want.switch_req)
            report_mismatch("switch_request", got[24], want.switch_req);
        if (got[26:25] != want.sel)
            report_mismatch("controller_select", got[26:25], want.sel);
        if (got[31:27] != '0)
            report_mismatch("padding", got[31:27], 0);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track
        sup_state_t next_state;
        reply_t     predicted;
        if (!rst_n)
        begin
            sup_state <= ST_INIT;
            drives_in_use <= 3'd7;
            expected_replies.delete();
            mismatch_total = 0;
            checked_total = 0;
            seen_mask = '0;
            mismatches <= 0;
            replies_pending <= 0;
            replies_checked <= 0;
            states_seen <= '0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
                check_reply(m_axis_tdata);
            if (cfg_valid && cfg_ready)
                drives_in_use <= cfg_data;
            if (s_axis_tvalid && s_axis_tready)
            begin
                next_state = sup_state;
                predicted = supervise_tick(s_axis_tdata, drives_in_use, next_state);
                sup_state <= next_state;
                expected_replies.push_back(predicted);
            end
            mismatches <= mismatch_total;
            replies_pending <= expected_replies.size();
            replies_checked <= checked_total;
            states_seen <= seen_mask;
        end
    end

endmodule

// ===== bench/tb_multi_drive_safety_supervisor_top.sv =====
`timescale 1ns / 1ps

module tb_multi_drive_safety_supervisor_top;
    import mdss_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int LONG_HOLD    = 200;
    localparam int PHASE_TICKS  = 160;

    localparam drive_status_t DS_NOT_READY = 3'd0;
    localparam drive_status_t DS_OTHER_LO  = 3'd6;
    localparam drive_status_t DS_OTHER_HI  = 3'd7;

    localparam logic [3:0] F_NONE  = 4'b0000;
    localparam logic [3:0] F_ESTOP = 4'b0001;
    localparam logic [3:0] F_FAULT = 4'b0010;
    localparam logic [3:0] F_TRAJ  = 4'b0100;
    localparam logic [3:0] F_RESET = 4'b1000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic [31:0] s_axis_tdata = '0;
    logic        m_axis_tready = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [2:0]  cfg_data = '0;
    logic        s_axis_tready;
    logic        m_axis_tvalid;
    logic [31:0] m_axis_tdata;
    logic        cfg_ready;

    int unsigned mismatches;
    int unsigned replies_pending;
    int unsigned replies_checked;
    logic [4:0]  states_seen;
    int unsigned ticks_sent = 0;
    int unsigned settings_used = 0;
    int unsigned cycle_count = 0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    multi_drive_safety_supervisor_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    supervisor_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .mismatches      (mismatches),
        .replies_pending (replies_pending),
        .replies_checked (replies_checked),
        .states_seen     (states_seen)
    );

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin : watchdog
        wait (cycle_count >= LIMIT_CYCLES);
        $display("FAIL");
        $finish;
    end

    function automatic logic [20:0] all_status(input drive_status_t s);
        return {7{s}};
    endfunction

    function automatic logic [31:0] make_tick(input logic [3:0] flags, input logic [20:0] statuses);
        return {7'b0, statuses, flags};
    endfunction

    function automatic logic [31:0] random_tick();
        logic [3:0]  flags;
        logic [20:0] statuses;
        int unsigned pick;
        flags[0] = ($urandom_range(0, 15) == 0);
        flags[1] = ($urandom_range(0, 9) == 0);
        flags[2] = 1'($urandom_range(0, 1));
        flags[3] = ($urandom_range(0, 2) == 0);
        pick = $urandom_range(0, 99);
        // mostly ladders that let the supervisor advance, the rest noise
        if (pick < 40)
            statuses = all_status(DS_OP_ENABLED);
        else if (pick < 65)
            statuses = all_status(DS_SWON_DISABLED);
        else
            statuses = 21'($urandom);
        if (pick < 65 && $urandom_range(0, 3) == 0)
            statuses[3 * $urandom_range(0, 6) +: 3] = 3'($urandom);
        return make_tick(flags, statuses);
    endfunction

    task automatic send_tick(input logic [31:0] payload);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= payload;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        ticks_sent++;
    endtask

    task automatic drain_replies();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (replies_pending != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_drive_count(input logic [2:0] count);
        drain_replies();
        cfg_valid <= 1'b1;
        cfg_data <= count;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    task automatic run_phase(input logic [2:0] count, input int unsigned items);
        int unsigned left;
        int unsigned burst;
        int unsigned gap;
        write_drive_count(count);
        left = items;
        while (left > 0)
        begin
            burst = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
            if (burst > left)
                burst = left;
            repeat (burst) send_tick(random_tick());
            left -= burst;
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    initial
    begin : sink_pacing
        int unsigned run_len;
        int unsigned ready_pct;
        int unsigned hold_index;
        hold_index = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_index < 2 && ticks_sent >= ((hold_index == 0) ? 200 : 800))
            begin
                // hold off long enough to back up the input side
                repeat (LONG_HOLD)
                begin
                    @(posedge clk);
                    m_axis_tready <= 1'b0;
                end
                hold_index++;
            end
            else
            begin
                case ($urandom_range(0, 4))
                    0, 1:    ready_pct = 100;
                    2:       ready_pct = 70;
                    3:       ready_pct = 30;
                    default: ready_pct = 0;
                endcase
                run_len = (ready_pct == 0) ? $urandom_range(1, 40) : $urandom_range(1, 50);
                repeat (run_len)
                begin
                    @(posedge clk);
                    m_axis_tready <= ($urandom_range(1, 100) <= ready_pct);
                end
            end
        end
    end

    initial
    begin : stimulus
        logic [2:0]  phase_counts [8];
        logic [20:0] ladder_mix;
        logic [20:0] fault_mix;
        phase_counts = '{3'd3, 3'd0, 3'd7, 3'd1, 3'd5, 3'd2, 3'd6, 3'd4};
        ladder_mix = {DS_FAULT, DS_OTHER_HI, DS_OTHER_LO, DS_SWITCHED_ON,
                      DS_READY, DS_SWON_DISABLED, DS_NOT_READY};
        fault_mix = {DS_SWON_DISABLED, DS_OTHER_HI, DS_SWON_DISABLED, DS_NOT_READY,
                     DS_FAULT, DS_FAULT, DS_SWON_DISABLED};

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // walk the ladder, then ready and active both ways
        send_tick(make_tick(F_NONE, ladder_mix));
        send_tick(make_tick(F_TRAJ, all_status(DS_OP_ENABLED)));
        send_tick(make_tick(F_NONE, all_status(DS_OP_ENABLED)));
        send_tick(make_tick(F_TRAJ, all_status(DS_OP_ENABLED)));
        send_tick(make_tick(F_TRAJ, ladder_mix));
        send_tick(make_tick(F_NONE, all_status(DS_OP_ENABLED)));
        send_tick(make_tick(F_TRAJ, all_status(DS_OP_ENABLED)));
        // leave active by override into estop, then clear it
        send_tick(make_tick(F_TRAJ | F_ESTOP | F_FAULT, all_status(DS_OP_ENABLED)));
        send_tick(make_tick(F_RESET | F_FAULT, all_status(DS_SWON_DISABLED)));
        send_tick(make_tick(F_RESET | F_ESTOP, all_status(DS_SWON_DISABLED)));
        send_tick(make_tick(F_RESET, ladder_mix));
        send_tick(make_tick(F_NONE, all_status(DS_OP_ENABLED)));
        send_tick(make_tick(F_TRAJ, all_status(DS_OP_ENABLED)));
        // fault path with resets and disables
        send_tick(make_tick(F_TRAJ | F_FAULT, all_status(DS_OP_ENABLED)));
        send_tick(make_tick(F_RESET, fault_mix));
        send_tick(make_tick(F_NONE, fault_mix));
        send_tick(make_tick(F_RESET | F_FAULT, all_status(DS_SWON_DISABLED)));
        send_tick(make_tick(F_RESET, all_status(DS_SWON_DISABLED)));
        // every field at its top value
        send_tick(make_tick(4'hF, all_status(DS_OTHER_HI)));
        send_tick(make_tick(F_RESET, all_status(DS_NOT_READY)));

        // no drives in use: init and fault fall through
        write_drive_count(3'd0);
        send_tick(make_tick(F_NONE, all_status(DS_OTHER_HI)));
        send_tick(make_tick(F_FAULT, all_status(DS_FAULT)));
        send_tick(make_tick(F_RESET, all_status(DS_FAULT)));
        send_tick(make_tick(F_ESTOP, all_status(DS_OP_ENABLED)));

        foreach (phase_counts[p])
            run_phase(phase_counts[p], PHASE_TICKS);

        drain_replies();
        repeat (4) @(posedge clk);

        $display("Ran %0d ticks across %0d drive-count settings, %0d results checked",
                 ticks_sent, settings_used, replies_checked);
        $display("Supervisor states reached (estop..init): %b", states_seen);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
